[rtl/core/cwlm_pkg.sv]
// Shared constants and types of the CT window/level mapper.
package cwlm_pkg;

	localparam int DENSITY_BITS = 16;
	localparam int GRAY_BITS    = 8;
	localparam int DIFF_BITS    = DENSITY_BITS + 1;
	localparam int NUM_BITS     = DIFF_BITS + GRAY_BITS;
	localparam int QUO_STEPS    = GRAY_BITS;
	localparam int STEP_BITS    = $clog2(QUO_STEPS);

	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;
	localparam int REG_IDX_LSB   = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic REG_LOWER = 1'b0;
	localparam logic REG_UPPER = 1'b1;

	localparam logic [GRAY_BITS-1:0] GRAY_FULL = '1;
	localparam logic [GRAY_BITS-1:0] GRAY_ZERO = '0;

	localparam logic signed [DENSITY_BITS-1:0] PAD_LIMIT    = DENSITY_BITS'(-16000);
	localparam logic signed [DENSITY_BITS-1:0] MIN_IN_RESET = DENSITY_BITS'(16000);
	localparam logic signed [DENSITY_BITS-1:0] MAX_IN_RESET = DENSITY_BITS'(-16000);
	localparam logic signed [DENSITY_BITS-1:0] LOWER_RESET  = DENSITY_BITS'(0);
	localparam logic signed [DENSITY_BITS-1:0] UPPER_RESET  = DENSITY_BITS'(255);

	localparam logic [1:0] CLS_ZERO = 2'd0;
	localparam logic [1:0] CLS_FULL = 2'd1;
	localparam logic [1:0] CLS_RAMP = 2'd2;

	typedef struct packed {
		logic signed [DENSITY_BITS-1:0] density;
		logic                           frame_start;
	} pixel_t;

	typedef struct packed {
		logic [GRAY_BITS-1:0]           gray_level;
		logic signed [DENSITY_BITS-1:0] input_min;
		logic signed [DENSITY_BITS-1:0] input_max;
		logic [GRAY_BITS-1:0]           output_min;
		logic [GRAY_BITS-1:0]           output_max;
		logic                           window_error;
	} result_t;

	typedef struct packed {
		logic signed [DENSITY_BITS-1:0] density;
		logic                           frame_start;
		logic                           window_error;
		logic [1:0]                     cls;
		logic [DENSITY_BITS-1:0]        range_w;
		logic [NUM_BITS-1:0]            num;
	} work_t;

endpackage

[rtl/core/cwlm_front.sv]
// Front end: accepts pixel requests and classifies them against the window.
module cwlm_front import cwlm_pkg::*; (
	input  pixel_t                         pixel,
	input  logic                           pixel_valid,
	output logic                           pixel_ready,
	input  logic signed [DENSITY_BITS-1:0] lower_threshold,
	input  logic signed [DENSITY_BITS-1:0] upper_threshold,
	output work_t                          work,
	output logic                           work_valid,
	input  logic                           work_ready
);

	logic signed [DIFF_BITS-1:0] range_s;
	logic signed [DIFF_BITS-1:0] offset_s;
	logic                        err;

	assign range_s  = DIFF_BITS'(upper_threshold) - DIFF_BITS'(lower_threshold);
	assign offset_s = DIFF_BITS'(pixel.density) - DIFF_BITS'(lower_threshold);
	assign err      = upper_threshold <= lower_threshold;

	always_comb begin
		work.density      = pixel.density;
		work.frame_start  = pixel.frame_start;
		work.window_error = err;
		work.range_w      = range_s[DENSITY_BITS-1:0];
		work.num          = {offset_s, {GRAY_BITS{1'b0}}} - {{GRAY_BITS{1'b0}}, offset_s};
		if (err) begin
			work.cls = CLS_ZERO;
		end else if (pixel.density < lower_threshold) begin
			work.cls = (pixel.density < PAD_LIMIT) ? CLS_FULL : CLS_ZERO;
		end else if (pixel.density > upper_threshold) begin
			work.cls = CLS_FULL;
		end else begin
			work.cls = CLS_RAMP;
		end
	end

	assign work_valid  = pixel_valid;
	assign pixel_ready = work_ready;

endmodule

[rtl/core/cwlm_queue.sv]
// Two-entry queue between the classifying front end and the divider back end.
module cwlm_queue import cwlm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  work_t push_data,
	input  logic  push_valid,
	output logic  push_ready,
	output work_t pop_data,
	output logic  pop_valid,
	input  logic  pop_ready
);

	work_t                entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 push;
	logic                 pop;

	assign push_ready = count_q != QCNT_BITS'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

endmodule

[rtl/core/cwlm_back.sv]
// Back end: restoring divider for the gray ramp, frame statistics, result register.
module cwlm_back import cwlm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  work_t   work,
	input  logic    work_valid,
	output logic    work_ready,
	output result_t result,
	output logic    result_valid,
	input  logic    result_ready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                     state_q;
	work_t                          item_q;
	logic [NUM_BITS-1:0]            rem_q;
	logic [NUM_BITS-1:0]            dvs_q;
	logic [GRAY_BITS-1:0]           quo_q;
	logic [STEP_BITS-1:0]           step_q;
	logic signed [DENSITY_BITS-1:0] min_in_q;
	logic signed [DENSITY_BITS-1:0] max_in_q;
	logic [GRAY_BITS-1:0]           min_out_q;
	logic [GRAY_BITS-1:0]           max_out_q;
	result_t                        result_q;
	logic                           result_valid_q;

	logic [NUM_BITS:0]              diff;
	logic                           fits;
	logic                           fin_go;
	logic [GRAY_BITS-1:0]           gray;
	logic signed [DENSITY_BITS-1:0] base_min_in;
	logic signed [DENSITY_BITS-1:0] base_max_in;
	logic [GRAY_BITS-1:0]           base_min_out;
	logic [GRAY_BITS-1:0]           base_max_out;
	result_t                        next_result;

	assign work_ready = state_q == ST_IDLE;
	assign diff       = {1'b0, rem_q} - {1'b0, dvs_q};
	assign fits       = !diff[NUM_BITS];
	assign fin_go     = (state_q == ST_FIN) && (!result_valid_q || result_ready);

	always_comb begin
		case (item_q.cls)
			CLS_RAMP: gray = quo_q;
			CLS_FULL: gray = GRAY_FULL;
			default:  gray = GRAY_ZERO;
		endcase
		base_min_in  = item_q.frame_start ? MIN_IN_RESET : min_in_q;
		base_max_in  = item_q.frame_start ? MAX_IN_RESET : max_in_q;
		base_min_out = item_q.frame_start ? GRAY_FULL : min_out_q;
		base_max_out = item_q.frame_start ? GRAY_ZERO : max_out_q;
		next_result.gray_level   = gray;
		next_result.input_min    = (item_q.density < base_min_in) ? item_q.density : base_min_in;
		next_result.input_max    = (item_q.density > base_max_in) ? item_q.density : base_max_in;
		next_result.output_min   = (gray < base_min_out) ? gray : base_min_out;
		next_result.output_max   = (gray > base_max_out) ? gray : base_max_out;
		next_result.window_error = item_q.window_error;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (work_valid) begin
					item_q <= work;
					rem_q  <= work.num;
					dvs_q  <= NUM_BITS'({work.range_w, {(GRAY_BITS-1){1'b0}}});
					step_q <= STEP_BITS'(QUO_STEPS - 1);
				end
			end
			ST_DIV: begin
				if (fits) begin
					rem_q <= diff[NUM_BITS-1:0];
				end
				quo_q  <= {quo_q[GRAY_BITS-2:0], fits};
				dvs_q  <= dvs_q >> 1;
				step_q <= step_q - STEP_BITS'(1);
			end
			default: begin
			end
		endcase
		if (fin_go) begin
			result_q <= next_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			min_in_q       <= MIN_IN_RESET;
			max_in_q       <= MAX_IN_RESET;
			min_out_q      <= GRAY_FULL;
			max_out_q      <= GRAY_ZERO;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (work_valid) begin
						state_q <= (work.cls == CLS_RAMP) ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fin_go) begin
				result_valid_q <= 1'b1;
				min_in_q       <= next_result.input_min;
				max_in_q       <= next_result.input_max;
				min_out_q      <= next_result.output_min;
				max_out_q      <= next_result.output_max;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

[rtl/core/ct_window_level_mapper_unit.sv]
// Top level of the CT window/level mapper: window registers, front end, queue, back end.
// Maps each signed density to an 8-bit gray level through the window held in the
// lower and upper threshold registers, and reports running input and gray extremes
// of the current frame with every result. A pixel inside the window passes through
// the back end in order: a pick-up state that takes it from the queue, the restoring
// divider that produces one quotient bit per cycle, and a finish state that retires it
// into the result register once that register is free. Pixels outside the window, and
// all pixels while the window is invalid, skip the divider. The front end classifies
// a pixel in the cycle it is accepted and a two-entry queue lets up to two pixels
// wait ahead of the divider. Write the thresholds only while no pixel is in flight.
module ct_window_level_mapper_unit import cwlm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pixel_t                   pixel,
	input  logic                     pixel_valid,
	output logic                     pixel_ready,
	output result_t                  result,
	output logic                     result_valid,
	input  logic                     result_ready,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	logic signed [DENSITY_BITS-1:0] lower_q;
	logic signed [DENSITY_BITS-1:0] upper_q;
	logic                           reg_idx;
	logic                           reg_write;
	work_t                          front_work;
	logic                           front_valid;
	logic                           front_ready;
	work_t                          back_work;
	logic                           back_valid;
	logic                           back_ready;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[REG_IDX_LSB];
	assign reg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LOWER_RESET;
			upper_q <= UPPER_RESET;
		end else if (reg_write) begin
			unique case (reg_idx)
				REG_LOWER: lower_q <= pwdata[DENSITY_BITS-1:0];
				REG_UPPER: upper_q <= pwdata[DENSITY_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LOWER: prdata = APB_DATA_BITS'(lower_q);
			REG_UPPER: prdata = APB_DATA_BITS'(upper_q);
			default:   prdata = '0;
		endcase
	end

	cwlm_front u_front (
		.pixel           (pixel),
		.pixel_valid     (pixel_valid),
		.pixel_ready     (pixel_ready),
		.lower_threshold (lower_q),
		.upper_threshold (upper_q),
		.work            (front_work),
		.work_valid      (front_valid),
		.work_ready      (front_ready)
	);

	cwlm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_work),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (back_work),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	cwlm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.work         (back_work),
		.work_valid   (back_valid),
		.work_ready   (back_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

[rtl/core/cwlm_checker.sv]
// Port-level checks of the CT window/level mapper and their binding to the top level.
module cwlm_checker import cwlm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input result_t result,
	input logic    result_valid,
	input logic    result_ready
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result request dropped before it was taken");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("stalled result changed");

	a_error_black: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.window_error |-> result.gray_level == GRAY_ZERO)
		else $error("invalid window gave a nonzero gray level");

	a_stats_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.output_min <= result.gray_level &&
			result.gray_level <= result.output_max &&
			result.input_min <= result.input_max)
		else $error("frame statistics do not bound the current pixel");

endmodule

bind ct_window_level_mapper_unit cwlm_checker u_cwlm_checker (.*);
